>>> rtl/core/rqtf_pkg.sv
// Shared types and constants for the read quality trim filter.
package rqtf_pkg;

    // Longest read that is counted; positions past it are dropped.
    localparam int MAX_READ_LEN = 4096;
    localparam int FIELD_W      = 13;
    localparam int SCORE_W      = 7;
    localparam int LOW_SCORE    = 3;
    localparam int MIN_KEEP_RST = 40;

    // Position and counter width: holds 0..MAX_READ_LEN.
    localparam int CNT_W = $clog2(MAX_READ_LEN + 1);
    // Compare width, wide enough for both counters and 13-bit registers.
    localparam int CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    // Running sum of (threshold - score), signed; |sum| < MAX_READ_LEN * 128.
    localparam int PS_W  = CNT_W + SCORE_W + 2;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_TRIM_THRESHOLD    = 3'd0,
        REG_HARD_CLIP_LENGTH  = 3'd1,
        REG_LOW_FILTER_ENABLE = 3'd2,
        REG_LOW_QUALITY_LIMIT = 3'd3,
        REG_MIN_KEEP_LENGTH   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [SCORE_W-1:0] trim_threshold;
        logic [FIELD_W-1:0] hard_clip_length;
        logic               low_filter_enable;
        logic [FIELD_W-1:0] low_quality_limit;
        logic [FIELD_W-1:0] min_keep_length;
    } t_cfg;

    typedef struct packed {
        logic [SCORE_W-1:0] phred_score;
        logic               read_end;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] kept_length;
        logic [FIELD_W-1:0] low_quality_count;
        logic               read_pass;
    } t_out_item;

endpackage

>>> rtl/core/rqtf_cfg_regs.sv
// Configuration register file with APB-style access.
module rqtf_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rqtf_pkg::PADDR_W-1:0]  paddr,
    input  logic [rqtf_pkg::PDATA_W-1:0]  pwdata,
    output logic [rqtf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output rqtf_pkg::t_cfg                o_cfg
);

    rqtf_pkg::t_cfg   r_cfg;
    rqtf_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = rqtf_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trim_threshold    <= '0;
            r_cfg.hard_clip_length  <= '0;
            r_cfg.low_filter_enable <= 1'b0;
            r_cfg.low_quality_limit <= '0;
            r_cfg.min_keep_length   <= rqtf_pkg::FIELD_W'(rqtf_pkg::MIN_KEEP_RST);
        end else if (w_wr) begin
            unique case (w_idx)
                rqtf_pkg::REG_TRIM_THRESHOLD: begin
                    r_cfg.trim_threshold <= pwdata[rqtf_pkg::SCORE_W-1:0];
                end
                rqtf_pkg::REG_HARD_CLIP_LENGTH: begin
                    r_cfg.hard_clip_length <= pwdata[rqtf_pkg::FIELD_W-1:0];
                end
                rqtf_pkg::REG_LOW_FILTER_ENABLE: begin
                    r_cfg.low_filter_enable <= pwdata[0];
                end
                rqtf_pkg::REG_LOW_QUALITY_LIMIT: begin
                    r_cfg.low_quality_limit <= pwdata[rqtf_pkg::FIELD_W-1:0];
                end
                rqtf_pkg::REG_MIN_KEEP_LENGTH: begin
                    r_cfg.min_keep_length <= pwdata[rqtf_pkg::FIELD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            rqtf_pkg::REG_TRIM_THRESHOLD:
                prdata = rqtf_pkg::PDATA_W'(r_cfg.trim_threshold);
            rqtf_pkg::REG_HARD_CLIP_LENGTH:
                prdata = rqtf_pkg::PDATA_W'(r_cfg.hard_clip_length);
            rqtf_pkg::REG_LOW_FILTER_ENABLE:
                prdata = rqtf_pkg::PDATA_W'(r_cfg.low_filter_enable);
            rqtf_pkg::REG_LOW_QUALITY_LIMIT:
                prdata = rqtf_pkg::PDATA_W'(r_cfg.low_quality_limit);
            rqtf_pkg::REG_MIN_KEEP_LENGTH:
                prdata = rqtf_pkg::PDATA_W'(r_cfg.min_keep_length);
            default: prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/rqtf_in_stage.sv
// Input register: holds one base until the trim core takes it.
module rqtf_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  rqtf_pkg::t_in_item i_in_data,
    output logic               o_in_stall,
    input  logic               i_advance,
    output logic               o_valid,
    output rqtf_pkg::t_in_item o_item
);

    logic               r_valid;
    rqtf_pkg::t_in_item r_item;
    logic               w_accept;

    // Stall only while a held base cannot move on this cycle.
    assign o_in_stall = r_valid && !i_advance;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
    end

endmodule

>>> rtl/core/rqtf_trim_core.sv
// Per-read running state, cut search and result register.
module rqtf_trim_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rqtf_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  rqtf_pkg::t_in_item  i_item,
    output logic                o_advance,
    output logic                o_out_valid,
    output rqtf_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    localparam int CNT_W = rqtf_pkg::CNT_W;
    localparam int CMP_W = rqtf_pkg::CMP_W;
    localparam int PS_W  = rqtf_pkg::PS_W;
    localparam int SW    = rqtf_pkg::SCORE_W;

    logic        [CNT_W-1:0] r_pos, n_pos;
    logic signed [PS_W-1:0]  r_psum, n_psum;
    logic signed [PS_W-1:0]  r_minp, n_minp;
    logic        [CNT_W-1:0] r_cut, n_cut;
    logic        [CNT_W-1:0] r_low, n_low;
    logic        [CNT_W-1:0] r_low_cut, n_low_cut;
    logic        [SW-1:0]    r_last, n_last;

    logic                    r_out_valid;
    rqtf_pkg::t_out_item     r_out;

    logic        [CMP_W-1:0] w_limit;
    logic                    w_in_range;
    logic signed [SW:0]      w_diff;
    logic        [CNT_W-1:0] w_kept, w_lowc;
    logic                    w_pass;
    logic                    w_emit;

    // A base without read end never waits on the output side.
    assign o_advance = i_valid && (!i_item.read_end || !r_out_valid || !i_out_stall);
    assign w_emit    = o_advance && i_item.read_end;

    always_comb begin
        w_limit = CMP_W'(rqtf_pkg::MAX_READ_LEN);
        if (i_cfg.hard_clip_length != '0 &&
            CMP_W'(i_cfg.hard_clip_length) < CMP_W'(rqtf_pkg::MAX_READ_LEN)) begin
            w_limit = CMP_W'(i_cfg.hard_clip_length);
        end
        w_in_range = CMP_W'(r_pos) < w_limit;
        w_diff = $signed({1'b0, i_cfg.trim_threshold}) - $signed({1'b0, i_item.phred_score});

        n_pos     = r_pos;
        n_psum    = r_psum;
        n_minp    = r_minp;
        n_cut     = r_cut;
        n_low     = r_low;
        n_low_cut = r_low_cut;
        n_last    = r_last;
        if (w_in_range) begin
            // Ties move the cut to the later position.
            if (r_psum <= r_minp) begin
                n_minp    = r_psum;
                n_cut     = r_pos;
                n_low_cut = r_low;
            end
            n_psum = r_psum + PS_W'(w_diff);
            if (i_item.phred_score <= SW'(rqtf_pkg::LOW_SCORE)) begin
                n_low = r_low + 1'b1;
            end
            n_last = i_item.phred_score;
            n_pos  = r_pos + 1'b1;
        end

        w_kept = n_pos;
        w_lowc = n_low;
        if (i_cfg.trim_threshold != '0 && n_pos != '0 && n_last < i_cfg.trim_threshold) begin
            w_kept = n_cut;
            w_lowc = n_low_cut;
        end
        w_pass = (w_kept != '0) &&
                 (CMP_W'(w_kept) >= CMP_W'(i_cfg.min_keep_length)) &&
                 !(i_cfg.low_filter_enable &&
                   CMP_W'(w_lowc) > CMP_W'(i_cfg.low_quality_limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_psum    <= '0;
            r_minp    <= '0;
            r_cut     <= '0;
            r_low     <= '0;
            r_low_cut <= '0;
            r_last    <= '0;
        end else if (o_advance) begin
            if (i_item.read_end) begin
                r_pos     <= '0;
                r_psum    <= '0;
                r_minp    <= '0;
                r_cut     <= '0;
                r_low     <= '0;
                r_low_cut <= '0;
                r_last    <= '0;
            end else begin
                r_pos     <= n_pos;
                r_psum    <= n_psum;
                r_minp    <= n_minp;
                r_cut     <= n_cut;
                r_low     <= n_low;
                r_low_cut <= n_low_cut;
                r_last    <= n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.kept_length       <= rqtf_pkg::FIELD_W'(w_kept);
            r_out.low_quality_count <= rqtf_pkg::FIELD_W'(w_lowc);
            r_out.read_pass         <= w_pass;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/read_quality_trim_filter_top.sv
// Top level of the read quality trim filter.
//
// Input channel: one base per transaction, i_in_data carries the phred score
// and a read end mark on the last base of a read. Output channel: one
// transaction per read, given for the base that carries read end, with kept
// length, low-quality base count in the kept part and a pass flag.
// Throughput: one base per cycle, unless a read end base waits on a stalled
// result. A read end base reaches o_out_valid through the input register,
// then the result register. The per-read sums and the cut search update once
// per base in a single add/compare step, which sets that rate.
// Reset (synchronous, active low) clears the per-read state, both valid
// flags and the registers to their defaults (min keep length 40).
// When the receiver stalls, the result holds; bases without read end keep
// flowing, and a read end base waits in the input register, stalling input.
// Write registers over the APB-style port only while the block is idle; the block does not enforce it.
module read_quality_trim_filter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  rqtf_pkg::t_in_item            i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output rqtf_pkg::t_out_item           o_out_data,
    input  logic                          i_out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rqtf_pkg::PADDR_W-1:0]  paddr,
    input  logic [rqtf_pkg::PDATA_W-1:0]  pwdata,
    output logic [rqtf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    rqtf_pkg::t_cfg     w_cfg;
    logic               w_advance;
    logic               w_valid;
    rqtf_pkg::t_in_item w_item;

    rqtf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rqtf_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_advance  (w_advance),
        .o_valid    (w_valid),
        .o_item     (w_item)
    );

    rqtf_trim_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_valid),
        .i_item      (w_item),
        .o_advance   (w_advance),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> rtl/core/rqtf_checker.sv
// Port-level checks for the read quality trim filter, bound to the top level.
module rqtf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input rqtf_pkg::t_out_item           o_out_data,
    input logic                          i_out_stall
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.kept_length <= rqtf_pkg::FIELD_W'(rqtf_pkg::MAX_READ_LEN))
        else $error("kept length beyond read limit");

    a_low_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.low_quality_count <= o_out_data.kept_length)
        else $error("low-quality count exceeds kept length");

    a_pass_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.read_pass |-> o_out_data.kept_length != '0)
        else $error("empty read passed");

endmodule

bind read_quality_trim_filter_top rqtf_checker u_rqtf_checker (.*);
